// ===== rtl/ltti_pkg.sv =====
// Shared types, sizes and codes for the lead-time threshold interpolator.
// No dependencies; every other file of the block but ltti_ram uses this package.
package ltti_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 24;
  localparam int VAL_W    = 32;
  localparam int ENT_W    = KEY_W + VAL_W;
  localparam int PROD_W   = VAL_W + KEY_W + 1;
  localparam int ACC_W    = PROD_W + 1;
  localparam int DVD_W    = VAL_W + KEY_W;
  localparam int DIV_CW   = $clog2(DVD_W + 1);

  localparam logic [1:0] OP_STORE  = 2'd0;
  localparam logic [1:0] OP_INTERP = 2'd1;
  localparam logic [1:0] OP_PART   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_UNEVEN    = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Read address selection.
  localparam logic [1:0] RS_IDX   = 2'd0;
  localparam logic [1:0] RS_IDXM1 = 2'd1;
  localparam logic [1:0] RS_J     = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [KEY_W-1:0]        lead_time;
    logic signed [VAL_W-1:0] threshold_in;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] threshold_out;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       clr_cnt;
    logic       cnt_inc;
    logic       idx_inc;
    logic       idx_dec;
    logic       idx_load_cnt;
    logic       set_pos_idx;
    logic       set_pos_cnt;
    logic       wr_new;
    logic       wr_shift;
    logic [1:0] rsel;
    logic       cap_prev;
    logic       cap_cur;
    logic       p_track;
    logic       res_rd;
    logic       set_st;
    logic [1:0] st;
    logic       mul1;
    logic       mul2;
    logic       mul3;
    logic       div_start;
    logic       res_div;
    logic       set_j;
    logic       j_zero;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       cnt_full;
    logic       last;
    logic       key_ge;
    logic       key_eq;
    logic       idx_zero;
    logic       at_pos;
    logic       gap_bad;
    logic       j_zero_c;
    logic       div_done;
  } sts_t;

endpackage

// ===== rtl/ltti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ltti_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on ltti_pkg.
module ltti_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ltti_pkg::DVD_W-1:0]  dividend,
  input  logic [ltti_pkg::KEY_W-1:0]  divisor,
  output logic                        done,
  output logic [ltti_pkg::DVD_W-1:0]  quotient
);

  logic [ltti_pkg::DVD_W-1:0]  quo_r;
  logic [ltti_pkg::KEY_W-1:0]  rem_r;
  logic [ltti_pkg::KEY_W-1:0]  dvs_r;
  logic [ltti_pkg::DIV_CW-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [ltti_pkg::KEY_W:0]    trial;
  logic                        fits;

  assign trial = {rem_r, quo_r[ltti_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= ltti_pkg::DIV_CW'(ltti_pkg::DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ltti_pkg::DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[ltti_pkg::DVD_W-2:0], fits};
      rem_r <= fits ? ltti_pkg::KEY_W'(trial - {1'b0, dvs_r})
                    : trial[ltti_pkg::KEY_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/ltti_dp.sv =====
// Datapath: entry RAM, scan registers, multiplier, divider and result register.
// Depends on ltti_pkg, ltti_ram and ltti_div; driven by ltti_ctrl commands.
module ltti_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  ltti_pkg::in_t   in_data,
  input  ltti_pkg::cmd_t  cmd,
  output ltti_pkg::sts_t  sts,
  output ltti_pkg::out_t  out_data
);

  logic [1:0]                        op_r;
  logic [ltti_pkg::KEY_W-1:0]        lt_r;
  logic signed [ltti_pkg::VAL_W-1:0] val_r;
  logic [ltti_pkg::CNT_W-1:0]        cnt_r;
  logic [ltti_pkg::IDX_W-1:0]        idx_r;
  logic [ltti_pkg::IDX_W-1:0]        pos_r;
  logic [ltti_pkg::IDX_W-1:0]        j_r;
  logic [ltti_pkg::KEY_W-1:0]        ka_r, kb_r, key0_r, gap_r;
  logic signed [ltti_pkg::VAL_W-1:0] va_r, vb_r;
  logic signed [ltti_pkg::PROD_W-1:0] prod_r;
  logic signed [ltti_pkg::ACC_W-1:0] acc_r;
  logic                              neg_r;
  logic signed [ltti_pkg::VAL_W-1:0] res_r;
  logic [1:0]                        st_r;
  ltti_pkg::out_t                    out_r;

  logic [ltti_pkg::ENT_W-1:0]        rdata, wdata;
  logic [ltti_pkg::IDX_W-1:0]        raddr;
  logic                              we;
  logic [ltti_pkg::KEY_W-1:0]        rd_key;
  logic signed [ltti_pkg::VAL_W-1:0] rd_val;
  logic signed [ltti_pkg::KEY_W:0]   dk_hi, dk_lo;
  logic [ltti_pkg::ACC_W-1:0]        mag;
  logic [ltti_pkg::DVD_W-1:0]        dvd;
  logic [ltti_pkg::KEY_W-1:0]        dvs;
  logic                              div_done;
  logic [ltti_pkg::DVD_W-1:0]        quo;

  assign rd_key = rdata[ltti_pkg::ENT_W-1:ltti_pkg::VAL_W];
  assign rd_val = rdata[ltti_pkg::VAL_W-1:0];

  always_comb begin
    case (cmd.rsel)
      ltti_pkg::RS_IDXM1: raddr = idx_r - 1'b1;
      ltti_pkg::RS_J:     raddr = j_r;
      default:            raddr = idx_r;
    endcase
  end

  assign we    = cmd.wr_new | cmd.wr_shift;
  assign wdata = cmd.wr_new ? {lt_r, val_r} : rdata;

  ltti_ram #(
    .WIDTH (ltti_pkg::ENT_W),
    .DEPTH (ltti_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign dk_hi = $signed({1'b0, kb_r}) - $signed({1'b0, lt_r});
  assign dk_lo = $signed({1'b0, lt_r}) - $signed({1'b0, ka_r});
  assign mag   = acc_r[ltti_pkg::ACC_W-1] ? ltti_pkg::ACC_W'(-acc_r)
                                          : ltti_pkg::ACC_W'(acc_r);
  assign dvd   = (op_r == ltti_pkg::OP_PART)
               ? ltti_pkg::DVD_W'(lt_r - key0_r) : mag[ltti_pkg::DVD_W-1:0];
  assign dvs   = (op_r == ltti_pkg::OP_PART) ? gap_r : kb_r - ka_r;

  ltti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clr_cnt) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.op;
      lt_r  <= in_data.lead_time;
      val_r <= in_data.threshold_in;
      idx_r <= '0;
      pos_r <= '0;
      gap_r <= '0;
      res_r <= '0;
      st_r  <= ltti_pkg::ST_OK;
    end else begin
      if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - 1'b1;
      end else if (cmd.idx_load_cnt) begin
        idx_r <= cnt_r[ltti_pkg::IDX_W-1:0];
      end
      if (cmd.set_pos_idx) begin
        pos_r <= idx_r;
      end else if (cmd.set_pos_cnt) begin
        pos_r <= cnt_r[ltti_pkg::IDX_W-1:0];
      end
      if (cmd.cap_prev || cmd.p_track) begin
        ka_r <= rd_key;
        va_r <= rd_val;
      end
      if (cmd.p_track) begin
        if (idx_r == '0) begin
          key0_r <= rd_key;
        end
        if (idx_r == ltti_pkg::IDX_W'(1)) begin
          gap_r <= rd_key - ka_r;
        end
      end
      if (cmd.cap_cur) begin
        kb_r <= rd_key;
        vb_r <= rd_val;
      end
      if (cmd.set_st) begin
        st_r <= cmd.st;
      end
      if (cmd.res_rd) begin
        res_r <= rd_val;
      end
      if (cmd.res_div) begin
        res_r <= neg_r ? -quo[ltti_pkg::VAL_W-1:0] : quo[ltti_pkg::VAL_W-1:0];
      end
    end
    if (cmd.mul1) begin
      prod_r <= va_r * dk_hi;
    end
    if (cmd.mul2) begin
      acc_r  <= ltti_pkg::ACC_W'(prod_r);
      prod_r <= vb_r * dk_lo;
    end
    if (cmd.mul3) begin
      acc_r <= acc_r + ltti_pkg::ACC_W'(prod_r);
    end
    if (cmd.div_start) begin
      neg_r <= acc_r[ltti_pkg::ACC_W-1];
    end
    if (cmd.set_j) begin
      j_r <= (quo >= ltti_pkg::DVD_W'(cnt_r))
           ? ltti_pkg::IDX_W'(cnt_r - 1'b1) : quo[ltti_pkg::IDX_W-1:0];
    end else if (cmd.j_zero) begin
      j_r <= '0;
    end
    if (cmd.out_load) begin
      out_r.threshold_out <= res_r;
      out_r.status        <= st_r;
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.cnt_zero = cnt_r == '0;
    sts.cnt_full = cnt_r == ltti_pkg::CNT_W'(ltti_pkg::CAPACITY);
    sts.last     = (ltti_pkg::CNT_W'(idx_r) + 1'b1) == cnt_r;
    sts.key_ge   = rd_key >= lt_r;
    sts.key_eq   = rd_key == lt_r;
    sts.idx_zero = idx_r == '0;
    sts.at_pos   = idx_r == pos_r;
    sts.gap_bad  = (idx_r > ltti_pkg::IDX_W'(1)) && ((rd_key - ka_r) != gap_r);
    sts.j_zero_c = (gap_r == '0) || (lt_r < key0_r);
    sts.div_done = div_done;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/ltti_ctrl.sv =====
// Controller state machine: sequences scans, shifts, multiply and divide.
// Depends on ltti_pkg; drives ltti_dp through the command struct.
module ltti_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_op,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ltti_pkg::sts_t sts,
  output ltti_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_INS   = 5'd3;
  localparam logic [4:0] S_SH    = 5'd4;
  localparam logic [4:0] S_SH_WR = 5'd5;
  localparam logic [4:0] S_MUL1  = 5'd6;
  localparam logic [4:0] S_MUL2  = 5'd7;
  localparam logic [4:0] S_MUL3  = 5'd8;
  localparam logic [4:0] S_DST   = 5'd9;
  localparam logic [4:0] S_DIVW  = 5'd10;
  localparam logic [4:0] S_PDIV  = 5'd11;
  localparam logic [4:0] S_PDW   = 5'd12;
  localparam logic [4:0] S_PRD   = 5'd13;
  localparam logic [4:0] S_PVAL  = 5'd14;
  localparam logic [4:0] S_NF    = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    cmd.rsel  = ltti_pkg::RS_IDX;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_op)
            ltti_pkg::OP_CLEAR: begin
              cmd.clr_cnt = 1'b1;
              state_nxt   = S_DONE;
            end
            ltti_pkg::OP_STORE: begin
              state_nxt = sts.cnt_zero ? S_INS : S_RD;
            end
            default: begin
              state_nxt = sts.cnt_zero ? S_NF : S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        unique case (sts.op)
          ltti_pkg::OP_STORE: begin
            if (sts.key_ge) begin
              if (sts.key_eq) begin
                cmd.wr_new = 1'b1;
                state_nxt  = S_DONE;
              end else begin
                cmd.set_pos_idx = 1'b1;
                state_nxt       = S_INS;
              end
            end else if (sts.last) begin
              cmd.set_pos_cnt = 1'b1;
              state_nxt       = S_INS;
            end else begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_RD;
            end
          end
          ltti_pkg::OP_INTERP: begin
            // Exact match, below the first key, or past the last key.
            if ((sts.key_ge && (sts.key_eq || sts.idx_zero)) ||
                (!sts.key_ge && sts.last)) begin
              cmd.res_rd = 1'b1;
              state_nxt  = S_DONE;
            end else if (sts.key_ge) begin
              cmd.cap_cur = 1'b1;
              state_nxt   = S_MUL1;
            end else begin
              cmd.cap_prev = 1'b1;
              cmd.idx_inc  = 1'b1;
              state_nxt    = S_RD;
            end
          end
          default: begin
            if (sts.gap_bad) begin
              cmd.set_st = 1'b1;
              cmd.st     = ltti_pkg::ST_UNEVEN;
              state_nxt  = S_DONE;
            end else begin
              cmd.p_track = 1'b1;
              if (sts.last) begin
                state_nxt = S_PDIV;
              end else begin
                cmd.idx_inc = 1'b1;
                state_nxt   = S_RD;
              end
            end
          end
        endcase
      end
      S_INS: begin
        if (sts.cnt_full) begin
          cmd.set_st = 1'b1;
          cmd.st     = ltti_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          cmd.idx_load_cnt = 1'b1;
          state_nxt        = S_SH;
        end
      end
      S_SH: begin
        if (sts.at_pos) begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rsel  = ltti_pkg::RS_IDXM1;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_nxt    = S_SH;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_DST;
      end
      S_DST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.res_div = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_PDIV: begin
        if (sts.j_zero_c) begin
          cmd.j_zero = 1'b1;
          state_nxt  = S_PRD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_PDW;
        end
      end
      S_PDW: begin
        if (sts.div_done) begin
          cmd.set_j = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        cmd.rsel  = ltti_pkg::RS_J;
        state_nxt = S_PVAL;
      end
      S_PVAL: begin
        cmd.res_rd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_NF: begin
        cmd.set_st = 1'b1;
        cmd.st     = ltti_pkg::ST_NOT_FOUND;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/lead_time_threshold_interpolator_unit.sv =====
// Top level of the lead-time threshold interpolator.
// Depends on ltti_pkg, ltti_ctrl and ltti_dp.
//
//   channel | direction | signals                      | payload
//   in      | input     | in_valid, in_stall, in_data  | ltti_pkg::in_t
//   out     | output    | out_valid, out_stall, out_data | ltti_pkg::out_t
//
// One request is handled at a time. Each entry walked is read, then compared;
// an insert then shifts the later entries up one at a time, an interpolation
// multiplies and divides, and a partitioned query divides unless the gap is zero
// or the lead time lies below the first key.
// Synchronous active-low reset empties the table.
// A finished result waits in the output register while the next request is taken;
// that next result then holds the block until the waiting one is accepted.
module lead_time_threshold_interpolator_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ltti_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ltti_pkg::out_t out_data
);

  ltti_pkg::cmd_t cmd;
  ltti_pkg::sts_t sts;

  ltti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ltti_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== rtl/ltti_checker.sv =====
// Port-level checker for the lead-time threshold interpolator, bound to the top.
// Depends on ltti_pkg and lead_time_threshold_interpolator_unit.
module ltti_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input ltti_pkg::out_t out_data
);

  // A result waiting on a stalled consumer must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only a successful result may carry a threshold.
  a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ltti_pkg::ST_OK) |-> out_data.threshold_out == '0)
    else $error("non-zero threshold with error status");

  // An accepted request makes the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken without going busy");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lead_time_threshold_interpolator_unit ltti_checker u_ltti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_lead_time_threshold_interpolator_unit.sv =====
// Self-checking testbench for the lead-time threshold interpolator.
// Depends on ltti_pkg and lead_time_threshold_interpolator_unit.
// Sends directed and random requests, predicts each result and compares it.
`timescale 1ns / 1ps

module tb_lead_time_threshold_interpolator_unit;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int EXP_DEPTH   = 1024;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  ltti_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  ltti_pkg::out_t out_data;

  lead_time_threshold_interpolator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predicted table contents.
  logic [ltti_pkg::KEY_W-1:0]        tbl_key [ltti_pkg::CAPACITY];
  logic signed [ltti_pkg::VAL_W-1:0] tbl_val [ltti_pkg::CAPACITY];
  int                                tbl_count;

  // Expected results in request order.
  ltti_pkg::out_t exp_fifo [EXP_DEPTH];
  int             exp_wr;
  int             exp_rd;
  int             fail_count;
  int             cycle_count;
  bit             send_gaps;
  bit             recv_gaps;
  int             hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result of one request and updates the predicted table.
  function automatic ltti_pkg::out_t predict_threshold(ltti_pkg::in_t req);
    ltti_pkg::out_t r;
    int pos;
    int j;
    longint l0, l1, x, num, gap;
    r.threshold_out = '0;
    r.status = ltti_pkg::ST_OK;
    case (req.op)
      ltti_pkg::OP_STORE: begin
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < req.lead_time) pos++;
        if (pos < tbl_count && tbl_key[pos] == req.lead_time) begin
          tbl_val[pos] = req.threshold_in;
        end else if (tbl_count >= ltti_pkg::CAPACITY) begin
          r.status = ltti_pkg::ST_FULL;
        end else begin
          for (int k = tbl_count; k > pos; k--) begin
            tbl_key[k] = tbl_key[k-1];
            tbl_val[k] = tbl_val[k-1];
          end
          tbl_key[pos] = req.lead_time;
          tbl_val[pos] = req.threshold_in;
          tbl_count++;
        end
      end
      ltti_pkg::OP_INTERP: begin
        if (tbl_count == 0) begin
          r.status = ltti_pkg::ST_NOT_FOUND;
        end else if (req.lead_time <= tbl_key[0]) begin
          r.threshold_out = tbl_val[0];
        end else if (req.lead_time >= tbl_key[tbl_count-1]) begin
          r.threshold_out = tbl_val[tbl_count-1];
        end else begin
          for (int i = 1; i < tbl_count; i++) begin
            if (req.lead_time == tbl_key[i]) begin
              r.threshold_out = tbl_val[i];
              break;
            end
            if (req.lead_time > tbl_key[i-1] && req.lead_time < tbl_key[i]) begin
              l0 = tbl_key[i-1];
              l1 = tbl_key[i];
              x = req.lead_time;
              num = longint'(tbl_val[i-1]) * (l1 - x) + longint'(tbl_val[i]) * (x - l0);
              r.threshold_out = ltti_pkg::VAL_W'(num / (l1 - l0));
              break;
            end
          end
        end
      end
      ltti_pkg::OP_PART: begin
        if (tbl_count == 0) begin
          r.status = ltti_pkg::ST_NOT_FOUND;
        end else if (tbl_count == 1) begin
          r.threshold_out = tbl_val[0];
        end else begin
          gap = tbl_key[1] - tbl_key[0];
          for (int i = 2; i < tbl_count; i++)
            if (longint'(tbl_key[i] - tbl_key[i-1]) != gap) r.status = ltti_pkg::ST_UNEVEN;
          if (r.status == ltti_pkg::ST_OK) begin
            if (gap == 0 || req.lead_time < tbl_key[0]) j = 0;
            else j = int'((longint'(req.lead_time) - tbl_key[0]) / gap);
            if (j >= tbl_count) j = tbl_count - 1;
            r.threshold_out = tbl_val[j];
          end
        end
      end
      default: tbl_count = 0;
    endcase
    return r;
  endfunction

  // Offers one request and holds it until it is taken. The valid stays high
  // afterwards so that back-to-back requests follow with no gap when send_gaps is off.
  task automatic send_request(logic [1:0] op, logic [ltti_pkg::KEY_W-1:0] lt,
                              logic [ltti_pkg::VAL_W-1:0] val);
    ltti_pkg::in_t req;
    int gap;
    req.op = op;
    req.lead_time = lt;
    req.threshold_in = val;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_fifo[exp_wr % EXP_DEPTH] = predict_threshold(req);
    exp_wr++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Receiver stall: random bursts, or a long hold-off when requested.
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
        out_stall <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    ltti_pkg::out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result threshold_out=%0d status=%0d",
               out_data.threshold_out, out_data.status);
        fail_count++;
      end else begin
        exp_r = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_data.threshold_out !== exp_r.threshold_out) begin
          $error("threshold_out expected %0d actual %0d",
                 exp_r.threshold_out, out_data.threshold_out);
          fail_count++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lead_time_threshold_interpolator_unit NOT OK");
      $finish;
    end
  end

  function automatic logic [ltti_pkg::VAL_W-1:0] rand_val();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_and_single();
    send_request(ltti_pkg::OP_INTERP, 24'd100, '0);
    send_request(ltti_pkg::OP_PART, 24'd100, '0);
    send_request(ltti_pkg::OP_STORE, 24'd500, 32'h0001_8000);
    send_request(ltti_pkg::OP_INTERP, 24'd0, '0);
    send_request(ltti_pkg::OP_PART, 24'hFFFFFF, '0);
    send_request(ltti_pkg::OP_STORE, 24'd500, 32'hFFFF_0000);
    send_request(ltti_pkg::OP_INTERP, 24'd500, '0);
  endtask

  task automatic test_interp_extremes();
    send_request(ltti_pkg::OP_STORE, 24'd0, 32'h8000_0000);
    send_request(ltti_pkg::OP_STORE, 24'hFFFFFF, 32'h7FFF_FFFF);
    send_request(ltti_pkg::OP_INTERP, 24'd3, '0);
    send_request(ltti_pkg::OP_INTERP, 24'd700, '0);
    send_request(ltti_pkg::OP_INTERP, 24'hFFFFFE, '0);
    send_request(ltti_pkg::OP_PART, 24'd600, '0);
    send_request(ltti_pkg::OP_CLEAR, 24'hABCDEF, 32'hFFFF_FFFF);
    send_request(ltti_pkg::OP_INTERP, 24'd1, '0);
  endtask

  task automatic test_partition();
    for (int i = 0; i < 4; i++)
      send_request(ltti_pkg::OP_STORE, 24'(10 + 20 * i), 32'(i * 1000 - 1500));
    send_request(ltti_pkg::OP_PART, 24'd5, '0);
    send_request(ltti_pkg::OP_PART, 24'd49, '0);
    send_request(ltti_pkg::OP_PART, 24'd1000, '0);
    send_request(ltti_pkg::OP_STORE, 24'd75, 32'd1);
    send_request(ltti_pkg::OP_PART, 24'd49, '0);
    send_request(ltti_pkg::OP_CLEAR, '0, '0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < ltti_pkg::CAPACITY; i++)
      send_request(ltti_pkg::OP_STORE, 24'(i * 3 + 1), rand_val());
    send_request(ltti_pkg::OP_STORE, 24'd1000, 32'd5);
    send_request(ltti_pkg::OP_STORE, 24'd4, 32'd5);
    send_request(ltti_pkg::OP_PART, 24'd50, '0);
    send_request(ltti_pkg::OP_INTERP, 24'd50, '0);
    wait_drained();
    send_request(ltti_pkg::OP_CLEAR, '0, '0);
  endtask

  // Holds the receiver off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    hold_off_cycles = 400;
    for (int i = 0; i < 6; i++)
      send_request(ltti_pkg::OP_STORE, 24'($urandom_range(0, 200)), rand_val());
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    logic [ltti_pkg::KEY_W-1:0] lt;
    int base, step;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        // Start a new evenly spaced table with random content.
        send_request(ltti_pkg::OP_CLEAR, 24'($urandom), $urandom);
        base = $urandom_range(0, 1000);
        step = $urandom_range(1, 300);
        for (int k = 0; k < $urandom_range(1, 10); k++)
          send_request(ltti_pkg::OP_STORE, 24'(base + k * step), rand_val());
      end
      case ($urandom_range(0, 9))
        0, 1, 2: op = ltti_pkg::OP_STORE;
        3, 4, 5: op = ltti_pkg::OP_INTERP;
        6, 7, 8: op = ltti_pkg::OP_PART;
        default: op = ($urandom_range(0, 3) == 0) ? ltti_pkg::OP_CLEAR : ltti_pkg::OP_INTERP;
      endcase
      if ($urandom_range(0, 7) == 0) lt = 24'($urandom);
      else lt = 24'($urandom_range(0, 4000));
      send_request(op, lt, rand_val());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    tbl_count = 0;
    exp_wr = 0;
    exp_rd = 0;
    fail_count = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_single();
    test_interp_extremes();
    test_partition();
    test_full_table();
    test_backpressure();
    test_random(300);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(60);
    wait_drained();
    if (fail_count == 0)
      $display("tb_lead_time_threshold_interpolator_unit OK");
    else
      $display("tb_lead_time_threshold_interpolator_unit NOT OK");
    $finish;
  end

endmodule
